FILE: rtl/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property that must also hold during reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/ced_pkg.sv
package ced_pkg;

    localparam int NUM_FIELDS = 7;
    localparam int BYTE_W     = 8;
    localparam int CURSOR_W   = 3;
    localparam int REQ_W      = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_UP    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DOWN  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_ENTER = 2'd3;

    // store indexes
    localparam logic [2:0] IX_SEC   = 3'd0;
    localparam logic [2:0] IX_MIN   = 3'd1;
    localparam logic [2:0] IX_HOUR  = 3'd2;
    localparam logic [2:0] IX_WDAY  = 3'd3;
    localparam logic [2:0] IX_DATE  = 3'd4;
    localparam logic [2:0] IX_MONTH = 3'd5;
    localparam logic [2:0] IX_YEAR  = 3'd6;

    // cursor positions
    localparam logic [CURSOR_W-1:0] CUR_HOUR  = 3'd0;
    localparam logic [CURSOR_W-1:0] CUR_MIN   = 3'd1;
    localparam logic [CURSOR_W-1:0] CUR_SEC   = 3'd2;
    localparam logic [CURSOR_W-1:0] CUR_DATE  = 3'd3;
    localparam logic [CURSOR_W-1:0] CUR_MONTH = 3'd4;
    localparam logic [CURSOR_W-1:0] CUR_YEAR  = 3'd5;
    localparam logic [CURSOR_W-1:0] CUR_LAST  = 3'd6;

    localparam logic [7:0] HOUR_MASK = 8'h1F;
    localparam logic [7:0] HOUR_HI   = 8'd12;
    localparam logic [7:0] MINSEC_HI = 8'd59;
    localparam logic [7:0] YEAR_HI   = 8'd99;
    localparam logic [7:0] SHORT_MON = 8'd30;
    localparam logic [7:0] LONG_MON  = 8'd31;
    localparam logic [7:0] MONTH_HI  = 8'd12;
    localparam logic [7:0] WDAY_HI   = 8'd7;

    typedef logic [NUM_FIELDS-1:0][BYTE_W-1:0] field_bytes_t;

    // editing in bit 0, then cursor, committed, then bytes sec..year
    typedef struct packed {
        field_bytes_t          vals;
        logic                  committed;
        logic [CURSOR_W-1:0]   cursor;
        logic                  editing;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;
    localparam int S_DATA_W = NUM_FIELDS * BYTE_W;

    function automatic logic [7:0] from_bcd(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'b0, b[7:4]};
        return (hi << 3) + (hi << 1) + {4'b0, b[3:0]};
    endfunction

    // v / 10 via reciprocal, exact for all 8-bit values
    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [18:0] prod;
        logic [7:0]  tens;
        logic [7:0]  ones;
        prod = 19'(v) * 19'd205;
        tens = 8'(prod >> 11);
        ones = v - 8'(tens * 8'd10);
        return {tens[3:0], ones[3:0]};
    endfunction

    function automatic logic [2:0] cursor_to_index(input logic [CURSOR_W-1:0] c);
        logic [2:0] idx;
        case (c)
            CUR_HOUR:  idx = IX_HOUR;
            CUR_MIN:   idx = IX_MIN;
            CUR_SEC:   idx = IX_SEC;
            CUR_DATE:  idx = IX_DATE;
            CUR_MONTH: idx = IX_MONTH;
            CUR_YEAR:  idx = IX_YEAR;
            default:   idx = IX_WDAY;
        endcase
        return idx;
    endfunction

endpackage

FILE: rtl/ced_core.sv
module ced_core
    import ced_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  logic [REQ_W-1:0]     req,
    input  field_bytes_t         snap,
    output result_t              res
);

    logic                active_reg, active_next;
    logic [CURSOR_W-1:0] cursor_reg, cursor_next;
    field_bytes_t        snap_reg, snap_next;
    field_bytes_t        vals_reg, vals_next;
    logic                committed;

    logic [2:0] idx;
    logic [7:0] cur_v;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] month;
    logic [7:0] days;
    logic [7:0] inc_v;
    logic [7:0] up_v;
    logic [7:0] down_v;

    // field under the cursor and its limits
    always_comb
    begin
        idx   = cursor_to_index(cursor_reg);
        cur_v = vals_reg[idx];
        month = vals_reg[IX_MONTH];
        days  = (month == 8'd4 || month == 8'd6 || month == 8'd9 || month == 8'd11)
                ? SHORT_MON : LONG_MON;
        unique case (idx)
            IX_HOUR:
            begin
                lo = 8'd1;
                hi = HOUR_HI;
            end
            IX_MIN, IX_SEC:
            begin
                lo = 8'd0;
                hi = MINSEC_HI;
            end
            IX_DATE:
            begin
                lo = 8'd1;
                hi = days;
            end
            IX_MONTH:
            begin
                lo = 8'd1;
                hi = MONTH_HI;
            end
            IX_YEAR:
            begin
                lo = 8'd0;
                hi = YEAR_HI;
            end
            default:
            begin
                lo = 8'd1;
                hi = WDAY_HI;
            end
        endcase
        inc_v  = cur_v + 8'd1;
        up_v   = (inc_v > hi) ? lo : inc_v;
        down_v = (cur_v <= lo) ? hi : cur_v - 8'd1;
    end

    always_comb
    begin
        active_next = active_reg;
        cursor_next = cursor_reg;
        snap_next   = snap_reg;
        vals_next   = vals_reg;
        committed   = 1'b0;
        if (step_en)
        begin
            unique case (req)
                REQ_LOAD:
                    snap_next = snap;
                REQ_UP:
                    if (!active_reg)
                    begin
                        for (int i = 0; i < NUM_FIELDS; i++)
                        begin
                            if (i == int'(IX_HOUR))
                                vals_next[i] = from_bcd(snap_reg[i] & HOUR_MASK);
                            else
                                vals_next[i] = from_bcd(snap_reg[i]);
                        end
                        cursor_next = CUR_HOUR;
                        active_next = 1'b1;
                    end
                    else
                        vals_next[idx] = up_v;
                REQ_DOWN:
                    if (active_reg)
                        vals_next[idx] = down_v;
                default:
                    if (active_reg)
                    begin
                        if (cursor_reg == CUR_LAST)
                        begin
                            cursor_next = CUR_HOUR;
                            active_next = 1'b0;
                            committed   = 1'b1;
                        end
                        else
                            cursor_next = cursor_reg + 3'd1;
                    end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cursor_reg <= '0;
            snap_reg   <= '0;
            vals_reg   <= '0;
        end
        else if (step_en)
        begin
            active_reg <= active_next;
            cursor_reg <= cursor_next;
            snap_reg   <= snap_next;
            vals_reg   <= vals_next;
        end
    end

    always_comb
    begin
        res.editing   = active_next;
        res.cursor    = cursor_next;
        res.committed = committed;
        for (int i = 0; i < NUM_FIELDS; i++)
            res.vals[i] = to_bcd(vals_next[i]);
    end

endmodule

FILE: rtl/clock_date_set_editor.sv
// the result is registered: a transaction passes through the input register and then the result register
// before it is valid on the master side
// throughput: one transaction per cycle while m_tready does not stall the result register
// each transaction updates the edit state in the single step between the two registers
// reset: rst_n low clears the valid flags of both stages, the edit mode, cursor, snapshot and edit values
module clock_date_set_editor
    import ced_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // input channel
    input  logic                s_tvalid,
    output logic                s_tready,
    // snap_seconds, snap_minutes, snap_hours, snap_weekday, snap_day_of_month,
    // snap_month, snap_year, 8 bits each from the lowest bit up
    input  logic [S_DATA_W-1:0] s_tdata,
    // req_type: 0 load, 1 up, 2 down, 3 enter
    input  logic [REQ_W-1:0]    s_tuser,
    // result channel
    output logic                m_tvalid,
    input  logic                m_tready,
    // editing, cursor[3], committed, out_seconds, out_minutes, out_hours, out_weekday,
    // out_day_of_month, out_month, out_year (8 each), zero padding on top
    output logic [M_DATA_W-1:0] m_tdata
);

    // input stage
    logic               in_valid_reg;
    logic [REQ_W-1:0]   in_req_reg;
    field_bytes_t       in_snap_reg;

    // result stage
    logic               out_valid_reg;
    result_t            out_reg;

    result_t            res_next;
    logic               advance;

    // move the held transaction into the result register when that slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_req_reg  <= s_tuser;
            in_snap_reg <= field_bytes_t'(s_tdata);
        end
    end

    // edit state and per-transaction update
    ced_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .req     (in_req_reg),
        .snap    (in_snap_reg),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_reg);

endmodule

FILE: rtl/ced_checker.sv
`include "assert_macros.svh"

module ced_checker
    import ced_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // a stalled result holds
    `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
        "result changed while stalled")

    // a commit ends editing and parks the cursor
    `ASSERT_CLK(a_commit_idle,
        m_tvalid && m_tdata[4] |-> !m_tdata[0] && m_tdata[3:1] == 3'd0,
        "commit left edit mode active")

    // idle results show cursor zero, and the cursor never passes the last field
    `ASSERT_CLK(a_cursor_range,
        m_tvalid |-> m_tdata[3:1] != 3'd7 && (m_tdata[0] || m_tdata[3:1] == 3'd0),
        "cursor out of range")

    // nothing is offered on the edge after reset was seen low
    `ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_tvalid, "result valid during reset")

endmodule

bind clock_date_set_editor ced_checker u_ced_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
